// ===== sv/cfl_pkg.sv =====
package cfl_pkg;

  localparam int unsigned TAPS_DEF = 64;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COEF_W   = 18;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned PROD_W   = SAMPLE_W + COEF_W;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_e;

  // control that travels with the operands into the multiply-accumulate unit
  typedef struct packed {
    logic start;
    logic vld;
    logic last;
  } mac_ctrl_t;

endpackage

// ===== sv/cfl_in_if.sv =====
interface cfl_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  opcode;
  logic [cfl_pkg::INDEX_W-1:0]           coef_index;
  logic signed [cfl_pkg::COEF_W-1:0]     coef_value;
  logic signed [cfl_pkg::SAMPLE_W-1:0]   sample_i;
  logic signed [cfl_pkg::SAMPLE_W-1:0]   sample_q;

  modport source (output valid, opcode, coef_index, coef_value, sample_i, sample_q,
                  input ready);
  modport sink   (input valid, opcode, coef_index, coef_value, sample_i, sample_q,
                  output ready);
endinterface

// ===== sv/cfl_out_if.sv =====
interface cfl_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [cfl_pkg::SAMPLE_W-1:0]   filtered_i;
  logic signed [cfl_pkg::SAMPLE_W-1:0]   filtered_q;

  modport source (output valid, filtered_i, filtered_q, input ready);
  modport sink   (input valid, filtered_i, filtered_q, output ready);
endinterface

// ===== sv/cfl_ram.sv =====
module cfl_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/cfl_mac.sv =====
module cfl_mac #(
  parameter int unsigned TAPS = cfl_pkg::TAPS_DEF,
  localparam int unsigned ACC_W = cfl_pkg::PROD_W + $clog2(TAPS)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cfl_pkg::mac_ctrl_t                  ctrl_i,
  input  logic signed [cfl_pkg::SAMPLE_W-1:0] dat_i_i,
  input  logic signed [cfl_pkg::SAMPLE_W-1:0] dat_q_i,
  input  logic signed [cfl_pkg::COEF_W-1:0]   coef_i,
  output logic                                done_o,
  output logic signed [cfl_pkg::SAMPLE_W-1:0] res_i_o,
  output logic signed [cfl_pkg::SAMPLE_W-1:0] res_q_o
);

  localparam int unsigned RND_W = ACC_W + 1;
  localparam logic signed [RND_W-1:0] HALF   = RND_W'(1) <<< 16;
  localparam logic signed [RND_W-1:0] MAX_Q15 = RND_W'(32767);
  localparam logic signed [RND_W-1:0] MIN_Q15 = -RND_W'(32768);

  logic signed [cfl_pkg::PROD_W-1:0] prod_i_q, prod_q_q;
  logic                              p_vld_q, p_last_q;
  logic signed [ACC_W-1:0]           acc_i_q, acc_q_q;
  logic                              done_q;

  // round half up to Q15, then clamp
  function automatic logic signed [cfl_pkg::SAMPLE_W-1:0] round_sat(
    input logic signed [ACC_W-1:0] acc
  );
    logic signed [RND_W-1:0] sum;
    logic signed [RND_W-1:0] shr;
    sum = RND_W'(acc) + HALF;
    shr = sum >>> 17;
    if (shr > MAX_Q15) begin
      round_sat = 16'sh7fff;
    end else if (shr < MIN_Q15) begin
      round_sat = 16'sh8000;
    end else begin
      round_sat = shr[cfl_pkg::SAMPLE_W-1:0];
    end
  endfunction

  always_ff @(posedge clk_i) begin
    prod_i_q <= dat_i_i * coef_i;
    prod_q_q <= dat_q_i * coef_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q  <= 1'b0;
      p_last_q <= 1'b0;
      done_q   <= 1'b0;
      acc_i_q  <= '0;
      acc_q_q  <= '0;
    end else begin
      p_vld_q  <= ctrl_i.vld;
      p_last_q <= ctrl_i.vld && ctrl_i.last;
      if (ctrl_i.start) begin
        acc_i_q <= '0;
        acc_q_q <= '0;
        done_q  <= 1'b0;
      end else if (p_vld_q) begin
        acc_i_q <= acc_i_q + ACC_W'(prod_i_q);
        acc_q_q <= acc_q_q + ACC_W'(prod_q_q);
        if (p_last_q) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o  = done_q;
  assign res_i_o = round_sat(acc_i_q);
  assign res_q_o = round_sat(acc_q_q);

endmodule

// ===== sv/complex_fir_lowpass.sv =====
// channel   dir  handshake      payload
// in_ch_i   in   valid/ready    opcode, coef_index, coef_value, sample_i, sample_q
// out_ch_o  out  valid/ready    filtered_i, filtered_q
//
// A coefficient load writes straight into the coefficient RAM. For a sample,
// one shared complex-by-real multiply-accumulate steps through the taps one
// per cycle, behind the registered reads of the delay and coefficient RAMs.
// Input ready is low while a sample is in progress; the output register lets
// the next item in while a result waits. Reset clears the valid bits, so
// delay lines and coefficients read as zero until written.
module complex_fir_lowpass #(
  parameter int unsigned TAPS = cfl_pkg::TAPS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  cfl_in_if.sink   in_ch_i,
  cfl_out_if.source out_ch_o
);

  localparam int unsigned PTR_W = $clog2(TAPS);
  localparam int unsigned SW    = cfl_pkg::SAMPLE_W;
  localparam int unsigned CW    = cfl_pkg::COEF_W;
  localparam logic [PTR_W-1:0] LAST_TAP = PTR_W'(TAPS - 1);

  cfl_pkg::state_e state_q, state_d;

  logic [PTR_W-1:0] wp_q, wp_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0] k_q, k_d;
  logic [TAPS-1:0]  dvalid_q, cvalid_q;
  logic             s1_vld_q, s1_last_q, dv_q, cv_q;
  logic             out_valid_q, out_valid_d;
  logic signed [SW-1:0] out_i_q, out_q_q;

  logic in_xfer, load_xfer, sample_xfer, coef_we, issue, out_load;
  logic [2*SW-1:0] delay_rdata;
  logic [CW-1:0]   coef_rdata;
  logic signed [SW-1:0] mac_i, mac_q, res_i, res_q;
  logic signed [CW-1:0] mac_coef;
  logic mac_done;
  cfl_pkg::mac_ctrl_t mac_ctrl;

  assign in_xfer     = in_ch_i.valid && in_ch_i.ready;
  assign load_xfer   = in_xfer && (in_ch_i.opcode == cfl_pkg::OP_LOAD);
  assign sample_xfer = in_xfer && (in_ch_i.opcode == cfl_pkg::OP_SAMPLE);
  // drop loads beyond the last tap
  assign coef_we     = load_xfer && ({1'b0, in_ch_i.coef_index} < 9'(TAPS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cfl_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    wp_d           = wp_q;
    rd_ptr_d       = rd_ptr_q;
    k_d            = k_q;
    in_ch_i.ready  = 1'b0;
    issue          = 1'b0;
    out_load       = 1'b0;
    unique case (state_q)
      cfl_pkg::ST_IDLE: begin
        in_ch_i.ready = 1'b1;
        if (sample_xfer) begin
          rd_ptr_d = wp_q;
          k_d      = '0;
          wp_d     = (wp_q == LAST_TAP) ? '0 : wp_q + 1'b1;
          state_d  = cfl_pkg::ST_RUN;
        end
      end
      cfl_pkg::ST_RUN: begin
        issue    = 1'b1;
        k_d      = k_q + 1'b1;
        rd_ptr_d = (rd_ptr_q == '0) ? LAST_TAP : rd_ptr_q - 1'b1;
        if (k_q == LAST_TAP) begin
          state_d = cfl_pkg::ST_FINISH;
        end
      end
      cfl_pkg::ST_FINISH: begin
        if (mac_done && (!out_valid_q || out_ch_o.ready)) begin
          out_load = 1'b1;
          state_d  = cfl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cfl_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ch_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      rd_ptr_q    <= '0;
      k_q         <= '0;
      dvalid_q    <= '0;
      cvalid_q    <= '0;
      s1_vld_q    <= 1'b0;
      s1_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      wp_q        <= wp_d;
      rd_ptr_q    <= rd_ptr_d;
      k_q         <= k_d;
      s1_vld_q    <= issue;
      s1_last_q   <= issue && (k_q == LAST_TAP);
      out_valid_q <= out_valid_d;
      if (sample_xfer) begin
        dvalid_q[wp_q] <= 1'b1;
      end
      if (coef_we) begin
        cvalid_q[in_ch_i.coef_index[PTR_W-1:0]] <= 1'b1;
      end
    end
  end

  // valid bits follow the registered RAM reads
  always_ff @(posedge clk_i) begin
    dv_q <= dvalid_q[rd_ptr_q];
    cv_q <= cvalid_q[k_q];
    if (out_load) begin
      out_i_q <= res_i;
      out_q_q <= res_q;
    end
  end

  cfl_ram #(
    .WIDTH (2 * SW),
    .DEPTH (TAPS)
  ) u_delay_ram (
    .clk_i   (clk_i),
    .we_i    (sample_xfer),
    .waddr_i (wp_q),
    .wdata_i ({in_ch_i.sample_i, in_ch_i.sample_q}),
    .raddr_i (rd_ptr_q),
    .rdata_o (delay_rdata)
  );

  cfl_ram #(
    .WIDTH (CW),
    .DEPTH (TAPS)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (in_ch_i.coef_index[PTR_W-1:0]),
    .wdata_i (in_ch_i.coef_value),
    .raddr_i (k_q),
    .rdata_o (coef_rdata)
  );

  assign mac_i    = dv_q ? $signed(delay_rdata[2*SW-1:SW]) : '0;
  assign mac_q    = dv_q ? $signed(delay_rdata[SW-1:0])    : '0;
  assign mac_coef = cv_q ? $signed(coef_rdata)             : '0;

  assign mac_ctrl.start = sample_xfer;
  assign mac_ctrl.vld   = s1_vld_q;
  assign mac_ctrl.last  = s1_last_q;

  cfl_mac #(
    .TAPS (TAPS)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .dat_i_i (mac_i),
    .dat_q_i (mac_q),
    .coef_i  (mac_coef),
    .done_o  (mac_done),
    .res_i_o (res_i),
    .res_q_o (res_q)
  );

  assign out_ch_o.valid      = out_valid_q;
  assign out_ch_o.filtered_i = out_i_q;
  assign out_ch_o.filtered_q = out_q_q;

  // the last tap leaves the RAMs only once the sequencer has stopped issuing
  a_last_in_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_last_q |-> state_q == cfl_pkg::ST_FINISH)
    else $error("last tap seen outside finish state");

  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cfl_pkg::ST_IDLE |-> !s1_vld_q)
    else $error("tap in flight while idle");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == cfl_pkg::ST_FINISH && $past(mac_done))
    else $error("result shown without a finished sum");

endmodule
